>>> design/epkd_pkg.sv
package epkd_pkg;

    // default matrix geometry
    localparam int EPKD_ROWS = 8;
    localparam int EPKD_COLS = 16;

    // fixed field widths of the ports
    localparam int IDX_W = 3;
    localparam int ROW_W = 16;
    localparam int EL_W  = 8;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] DEB_RESET = CNT_W'(5);

    // per-row status out of the update logic
    typedef struct packed {
        logic changed;
        logic settling;
    } t_row_flags;

endpackage

>>> design/epkd_row_mem.sv
module epkd_row_mem #(
    parameter int ROWS = 8,
    parameter int EW   = 144,
    parameter int AW   = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [EW-1:0] o_rd_data,
    output logic          o_rd_valid,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [EW-1:0] i_wr_data
);

    logic [EW-1:0]   r_mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    logic [EW-1:0]   r_rd_data;
    logic            r_rd_vld;

    // row storage, one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // written-since-reset flags; an unwritten row reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_addr] <= 1'b1;
        end
    end

    // registered read, write-first on an address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
                r_rd_vld  <= 1'b1;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
                r_rd_vld  <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_vld;

endmodule

>>> design/epkd_row_update.sv
module epkd_row_update #(
    parameter int NC = 16
) (
    input  logic [NC*(epkd_pkg::CNT_W+1)-1:0] i_entry,
    input  logic [NC-1:0]                     i_raw,
    input  logic [epkd_pkg::EL_W-1:0]         i_elapsed_ms,
    input  logic [epkd_pkg::CNT_W-1:0]        i_debounce_ms,
    output logic [NC*(epkd_pkg::CNT_W+1)-1:0] o_entry,
    output logic [epkd_pkg::ROW_W-1:0]        o_cooked,
    output epkd_pkg::t_row_flags              o_flags
);
    import epkd_pkg::*;

    localparam int CB = NC * CNT_W;   // cooked bits sit above the counters

    logic [NC-1:0] cooked_old;
    logic [NC-1:0] flips;
    logic [NC-1:0] busy;
    logic [NC-1:0] cooked_new;

    assign cooked_old = i_entry[CB +: NC];

    for (genvar c = 0; c < NC; c++) begin : g_col
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] dec;
        logic [CNT_W-1:0] nxt;

        assign cnt = i_entry[c*CNT_W +: CNT_W];
        // saturating countdown; an idle counter stays at zero
        assign dec = (cnt <= i_elapsed_ms) ? '0 : cnt - i_elapsed_ms;
        assign flips[c] = (i_raw[c] ^ cooked_old[c]) && (dec == '0);
        assign nxt = flips[c] ? i_debounce_ms : dec;
        assign busy[c] = (nxt != '0);
        assign o_entry[c*CNT_W +: CNT_W] = nxt;
    end

    assign cooked_new       = cooked_old ^ flips;
    assign o_entry[CB +: NC] = cooked_new;
    assign o_cooked         = ROW_W'(cooked_new);
    assign o_flags.changed  = |flips;
    assign o_flags.settling = |busy;

endmodule

>>> design/eager_per_key_debounce.sv
// Eager per-key debounce for a scanned key matrix.
// Input channel (i_in_valid / o_in_ready): one request per scanned row, carrying
// the row index, the raw column bits and the milliseconds since the last scan.
// Output channel (o_out_valid / i_out_ready): one result per request, in order:
// the cooked row, a changed flag and a settling flag (some counter still running).
// Config: i_cfg_we writes the hold-off time; write it only while the block is idle.
// Path: an accepted request waits in the update slot for its memory read, and
// its result is then registered in the output register that drives o_out_valid.
// Throughput: one request per cycle while results are taken. All per-row state
// (counters and cooked bits) sits in one row-wide memory with a registered read;
// the read of the next request and the write-back of the current one share a cycle,
// and the memory's write-first bypass covers the same row on consecutive requests.
// Reset: counters and cooked bits read as zero (per-row written flags, no clearing
// pass), hold-off returns to 5 ms, both pipeline slots empty.
// Stall: a held result stays put; one more request is taken into the update
// slot, after which o_in_ready drops until the receiver takes the result.
// Rows at or above ROWS give an all-zero result and leave the state alone.
module eager_per_key_debounce #(
    parameter int ROWS = epkd_pkg::EPKD_ROWS,
    parameter int COLS = epkd_pkg::EPKD_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [epkd_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [epkd_pkg::IDX_W-1:0]    i_row_index,
    input  logic [epkd_pkg::ROW_W-1:0]    i_raw_row,
    input  logic [epkd_pkg::EL_W-1:0]     i_elapsed_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [epkd_pkg::ROW_W-1:0]    o_cooked_row,
    output logic                          o_row_changed,
    output logic                          o_row_settling
);
    import epkd_pkg::*;

    // columns above the raw field width never see a raw bit, so they stay idle
    localparam int NC = (COLS < ROW_W) ? COLS : ROW_W;
    localparam int EW = NC * (CNT_W + 1);
    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // update slot: request waiting on its memory read
    logic             r_s1_vld;
    logic             r_s1_ok;
    logic [NC-1:0]    r_s1_raw;
    logic [EL_W-1:0]  r_s1_el;
    logic [AW-1:0]    r_s1_addr;

    // output register
    logic             r_out_vld;
    logic [ROW_W-1:0] r_cooked;
    logic             r_changed;
    logic             r_settling;

    logic [CNT_W-1:0] r_deb;

    logic             accept;
    logic             s1_adv;
    logic             row_ok_in;
    logic [AW-1:0]    addr_in;
    logic [EW-1:0]    rd_data;
    logic             rd_vld;
    logic [EW-1:0]    cur_entry;
    logic [EW-1:0]    n_entry;
    logic [ROW_W-1:0] n_cooked;
    t_row_flags       n_flags;

    assign row_ok_in  = (int'(i_row_index) < ROWS);
    assign addr_in    = AW'(i_row_index);

    // slot moves on when the output register is empty or being drained
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    epkd_row_mem #(
        .ROWS (ROWS),
        .EW   (EW),
        .AW   (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept && row_ok_in),
        .i_rd_addr  (addr_in),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_vld),
        .i_wr_en    (s1_adv && r_s1_ok),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (n_entry)
    );

    // never-written row behaves as all-zero
    assign cur_entry = rd_vld ? rd_data : '0;

    epkd_row_update #(
        .NC (NC)
    ) u_upd (
        .i_entry       (cur_entry),
        .i_raw         (r_s1_raw),
        .i_elapsed_ms  (r_s1_el),
        .i_debounce_ms (r_deb),
        .o_entry       (n_entry),
        .o_cooked      (n_cooked),
        .o_flags       (n_flags)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_deb     <= DEB_RESET;
        end else begin
            if (i_cfg_we) begin
                r_deb <= i_cfg_data;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ok   <= row_ok_in;
            r_s1_raw  <= i_raw_row[NC-1:0];
            r_s1_el   <= i_elapsed_ms;
            r_s1_addr <= addr_in;
        end
        if (s1_adv) begin
            r_cooked   <= r_s1_ok ? n_cooked : '0;
            r_changed  <= r_s1_ok && n_flags.changed;
            r_settling <= r_s1_ok && n_flags.settling;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_cooked_row   = r_cooked;
    assign o_row_changed  = r_changed;
    assign o_row_settling = r_settling;

endmodule

>>> design/epkd_checker.sv
module epkd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [epkd_pkg::ROW_W-1:0] o_cooked_row,
    input logic                       o_row_changed,
    input logic                       o_row_settling
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cooked_row)
            && $stable(o_row_changed) && $stable(o_row_settling))
        else $error("held result changed");

    // an accepted request is followed by a valid result on the output
    a_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("accepted request left no result");

    // input only backs up when the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind eager_per_key_debounce epkd_checker u_epkd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_cooked_row   (o_cooked_row),
    .o_row_changed  (o_row_changed),
    .o_row_settling (o_row_settling)
);

>>> sim/tb_top.sv
`timescale 1ns / 100ps

// Debounce checker for the per-key eager debounce block.
// Row scan requests are queued by the stimulus thread and pushed through the
// input channel by a falling-edge driver; a rising-edge monitor checks each
// cooked-row result against a software copy of the counters and cooked bits.
module tb_top;
    import epkd_pkg::*;

    localparam int CLK_HALF     = 2;          // 4 ns period
    localparam int RESET_CYCLES = 8;
    localparam int LIMIT_CYCLES = 1_000_000;  // far above the slowest legal run
    localparam int PIPE_DRAIN   = 8;          // margin for the pipeline to run dry
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;

    // one scanned row going in, one cooked row coming out
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [ROW_W-1:0] raw;
        logic [EL_W-1:0]  el;
    } t_scan_req;

    typedef struct packed {
        logic [ROW_W-1:0] cooked;
        logic             changed;
        logic             settling;
    } t_row_status;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [IDX_W-1:0] i_row_index;
    logic [ROW_W-1:0] i_raw_row;
    logic [EL_W-1:0]  i_elapsed_ms;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [ROW_W-1:0] o_cooked_row;
    logic             o_row_changed;
    logic             o_row_settling;

    eager_per_key_debounce DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_row_index    (i_row_index),
        .i_raw_row      (i_raw_row),
        .i_elapsed_ms   (i_elapsed_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cooked_row   (o_cooked_row),
        .o_row_changed  (o_row_changed),
        .o_row_settling (o_row_settling)
    );

    // ------------------------------------------------------------------
    // Shadow of the block's state: one hold-off counter per key, the
    // cooked bits per row, and the hold-off setting last written.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] hold_ms     [EPKD_ROWS][EPKD_COLS];
    logic [ROW_W-1:0] cooked_bits [EPKD_ROWS];
    logic [CNT_W-1:0] holdoff_ms;

    // "Physical" key state per row used to build bouncy but sane scans
    logic [ROW_W-1:0] true_keys   [EPKD_ROWS];

    t_scan_req   pending_scans [$];    // requests waiting for the driver
    t_row_status expected_rows [$];    // cooked rows owed by the block

    t_scan_req   next_scan;
    t_row_status want;
    logic        scan_taken;           // request handshake seen at last rising edge
    bit          idle_on;              // random gaps/stalls enabled for this phase
    int          req_gap;
    int          stall_left;
    int          cycle_count;
    int          errors;
    int          scans_sent;
    int          results_seen;
    int          changed_seen;
    int          settling_seen;
    int          settings_used;

    // Apply one scan to the shadow state and return the row it should yield.
    // Counters run down first (stopping at zero), then each key whose raw
    // bit disagrees with its cooked bit and whose counter is idle flips and
    // reloads from the hold-off setting.
    function automatic t_row_status debounce_row(input t_scan_req r);
        t_row_status      res;
        logic [ROW_W-1:0] cooked;
        logic [ROW_W-1:0] delta;
        logic [CNT_W-1:0] cnt;
        res    = '0;
        cooked = cooked_bits[r.row];
        delta  = r.raw ^ cooked;
        for (int c = 0; c < EPKD_COLS; c++) begin
            cnt = hold_ms[r.row][c];
            if (cnt != '0) begin
                cnt = (cnt <= r.el) ? '0 : cnt - r.el;
            end
            if (delta[c] && cnt == '0) begin
                cooked[c]    = ~cooked[c];
                cnt          = holdoff_ms;
                res.changed  = 1'b1;
            end
            if (cnt != '0) begin
                res.settling = 1'b1;
            end
            hold_ms[r.row][c] = cnt;
        end
        cooked_bits[r.row] = cooked;
        res.cooked         = cooked;
        return res;
    endfunction

    // Idle lengths: none while gaps are off; else mostly nothing or a short gap, now and then a long hole.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 45) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request side, rising edge: note the handshake and predict the result.
    // Also owns the cycle watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        scan_taken = i_rst_n && i_in_valid && o_in_ready;
        if (scan_taken) begin
            expected_rows.push_back(debounce_row({i_row_index, i_raw_row, i_elapsed_ms}));
            scans_sent++;
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: watchdog expired, %0d requests queued, %0d results owed",
                     $time, pending_scans.size(), expected_rows.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request driver, falling edge. Valid holds with a steady payload until
    // the handshake; after each accepted request an optional gap follows.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || scan_taken) begin
            if (req_gap > 0) begin
                req_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_scans.size() != 0) begin
                next_scan = pending_scans.pop_front();
                i_row_index  <= next_scan.row;
                i_raw_row    <= next_scan.raw;
                i_elapsed_ms <= next_scan.el;
                i_in_valid   <= 1'b1;
                req_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure, falling edge: random stalls of the receiver.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 20) begin
                stall_left = pick_stall();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor, rising edge: every accepted result against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected result cooked=%h changed=%b settling=%b",
                         $time, o_cooked_row, o_row_changed, o_row_settling);
            end else begin
                want = expected_rows.pop_front();
                if (want.changed) changed_seen++;
                if (want.settling) settling_seen++;
                if (o_cooked_row !== want.cooked) begin
                    errors++;
                    $display("%0t: cooked_row expected %h actual %h",
                             $time, want.cooked, o_cooked_row);
                end
                if (o_row_changed !== want.changed) begin
                    errors++;
                    $display("%0t: row_changed expected %b actual %b",
                             $time, want.changed, o_row_changed);
                end
                if (o_row_settling !== want.settling) begin
                    errors++;
                    $display("%0t: row_settling expected %b actual %b",
                             $time, want.settling, o_row_settling);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_scan(input int row, input int raw, input int el);
        t_scan_req s;
        s.row = IDX_W'(row);
        s.raw = ROW_W'(raw);
        s.el  = EL_W'(el);
        pending_scans.push_back(s);
    endtask

    // Sender holds off until every owed result is back, then lets the
    // pipeline run dry before anything else happens.
    task automatic wait_drained();
        while (pending_scans.size() != 0 || i_in_valid || expected_rows.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    // Hold-off write; only called with the block idle.
    task automatic set_holdoff(input logic [CNT_W-1:0] ms);
        @(negedge i_clk);
        i_cfg_data <= ms;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        holdoff_ms = ms;
        settings_used++;
    endtask

    // Mostly realistic scans: a stable key state per row with occasional
    // presses/releases and sparse contact bounce on top, small elapsed times.
    // The rest is unrestricted noise over all fields.
    task automatic queue_random_phase(input int n);
        int               row;
        int               pick;
        logic [ROW_W-1:0] bounce;
        logic [EL_W-1:0]  el;
        for (int i = 0; i < n; i++) begin
            row = $urandom_range(0, EPKD_ROWS - 1);
            if ($urandom_range(0, 99) < 70) begin
                if ($urandom_range(0, 99) < 15) begin
                    true_keys[row] = true_keys[row] ^ ROW_W'($urandom() & $urandom());
                end
                bounce = '0;
                if ($urandom_range(0, 99) < 40) begin
                    bounce = ROW_W'($urandom() & $urandom() & $urandom());
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    el = EL_W'($urandom_range(0, 4));
                end else if (pick < 90) begin
                    el = EL_W'($urandom_range(5, 40));
                end else if (pick < 95) begin
                    el = EL_W'($urandom_range(41, 254));
                end else begin
                    el = 8'd255;
                end
                queue_scan(row, int'(true_keys[row] ^ bounce), int'(el));
            end else begin
                queue_scan(row, $urandom_range(0, 16'hFFFF), $urandom_range(0, 255));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CNT_W-1:0] phase_ms [NUM_PHASES];

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_out_ready  = 1'b0;
        i_row_index  = '0;
        i_raw_row    = '0;
        i_elapsed_ms = '0;
        idle_on      = 1'b1;
        scan_taken   = 1'b0;
        req_gap      = 0;
        stall_left   = 0;
        cycle_count  = 0;
        errors       = 0;
        scans_sent   = 0;
        results_seen = 0;
        changed_seen = 0;
        settling_seen = 0;
        settings_used = 0;
        holdoff_ms   = DEB_RESET;
        for (int r = 0; r < EPKD_ROWS; r++) begin
            cooked_bits[r] = '0;
            true_keys[r]   = '0;
            for (int c = 0; c < EPKD_COLS; c++) begin
                hold_ms[r][c] = '0;
            end
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset hold-off of 5 ms
        queue_scan(0, 16'hFFFF, 0);     // whole row flips, counters loaded
        queue_scan(0, 16'h0000, 0);     // blocked: counters still running
        queue_scan(0, 16'h0000, 3);     // counters down to 2, still blocked
        queue_scan(0, 16'h0000, 2);     // elapsed equals counter: released and flips
        queue_scan(0, 16'h0000, 255);   // saturated elapsed, row settles
        queue_scan(7, 16'hA5A5, 255);
        queue_scan(7, 16'h5A5A, 4);     // A5A5 keys held with counters at 1, idle 5A5A keys flip
        queue_scan(7, 16'h5A5A, 1);
        queue_scan(3, 16'h0001, 0);
        queue_scan(3, 16'h8000, 0);     // top column flips, bottom one held
        queue_scan(5, 16'h0000, 0);     // idle row, zero elapsed
        queue_scan(6, 16'hFFFF, 255);
        wait_drained();

        // Directed, no hold-off: raw follows straight through
        set_holdoff(8'd0);
        queue_scan(1, 16'hFFFF, 0);
        queue_scan(1, 16'h0000, 0);
        queue_scan(1, 16'h1234, 255);
        wait_drained();

        // Directed, longest hold-off
        set_holdoff(8'd255);
        queue_scan(2, 16'hFFFF, 0);
        queue_scan(2, 16'h0000, 254);
        queue_scan(2, 16'h0000, 1);
        queue_scan(2, 16'h0000, 255);
        wait_drained();

        // Random phases, each with its own hold-off; one of them runs with
        // both sides always ready to cover back-to-back traffic.
        phase_ms[0] = 8'd1;
        phase_ms[1] = 8'd5;
        phase_ms[2] = 8'd30;
        phase_ms[3] = 8'd255;
        phase_ms[4] = 8'd0;
        phase_ms[5] = CNT_W'($urandom_range(0, 255));
        phase_ms[6] = 8'd2;
        phase_ms[7] = 8'd10;
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_holdoff(phase_ms[p]);
            idle_on = (p != 2);
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        $display("Ran %0d row scans under %0d hold-off writes with random gaps and stalls;",
                 scans_sent, settings_used);
        $display("%0d results checked, %0d with a flip, %0d with counters still running.",
                 results_seen, changed_seen, settling_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> eager_per_key_debounce.f
design/epkd_pkg.sv
design/epkd_row_mem.sv
design/epkd_row_update.sv
design/eager_per_key_debounce.sv
design/epkd_checker.sv
sim/tb_top.sv
